FILE: rtl/core/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants, codes and types for the ring deque with search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

    // Storage geometry (power-of-two depth, so slot arithmetic wraps freely)
    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int DW    = 32;
    localparam int CMDW  = 4;
    localparam int IDXW  = 8;
    localparam int POSW  = 8;
    localparam int STW   = 3;

    // Command codes
    localparam logic [CMDW-1:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [CMDW-1:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [CMDW-1:0] CMD_POP_BACK   = 4'd2;
    localparam logic [CMDW-1:0] CMD_POP_FRONT  = 4'd3;
    localparam logic [CMDW-1:0] CMD_READ       = 4'd4;
    localparam logic [CMDW-1:0] CMD_WRITE      = 4'd5;
    localparam logic [CMDW-1:0] CMD_LIN_SEARCH = 4'd6;
    localparam logic [CMDW-1:0] CMD_BIN_SEARCH = 4'd7;
    localparam logic [CMDW-1:0] CMD_CLEAR      = 4'd8;

    // Status codes
    localparam logic [STW-1:0] STAT_OK    = 3'd0;
    localparam logic [STW-1:0] STAT_FULL  = 3'd1;
    localparam logic [STW-1:0] STAT_EMPTY = 3'd2;
    localparam logic [STW-1:0] STAT_RANGE = 3'd3;
    localparam logic [STW-1:0] STAT_MISS  = 3'd4;
    localparam logic [STW-1:0] STAT_ABOVE = 3'd5;

    typedef logic [AW-1:0]        t_addr;
    typedef logic signed [DW-1:0] t_elem;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_LIN_RD,
        ST_LIN_CMP,
        ST_BIN_RD,
        ST_BIN_CMP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/rdq_if.sv
// ----------------------------------------------------------------------------
// rdq_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdq_in_if;
    import rdq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMDW-1:0]        cmd;
    logic signed [DW-1:0]   value;
    logic [IDXW-1:0]        index;

    modport source (output valid, output cmd, output value, output index, input ready);
    modport sink   (input valid, input cmd, input value, input index, output ready);
endinterface

interface rdq_out_if;
    import rdq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [DW-1:0]   data;
    logic [POSW-1:0]        position;
    logic [STW-1:0]         status;
    logic [CW-1:0]          length;

    modport source (output valid, output data, output position, output status,
                    output length, input ready);
    modport sink   (input valid, input data, input position, input status,
                    input length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rdq_store.sv
// ----------------------------------------------------------------------------
// rdq_store
// Element storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdq_store (
    input  wire               i_clk,
    input  wire               i_we,
    input  wire rdq_pkg::t_addr i_waddr,
    input  wire rdq_pkg::t_elem i_wdata,
    input  wire rdq_pkg::t_addr i_raddr,
    output rdq_pkg::t_elem    o_rdata
);
    import rdq_pkg::*;

    t_elem r_mem [DEPTH];
    t_elem r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/ring_deque_with_search_top.sv
// ----------------------------------------------------------------------------
// ring_deque_with_search_top
// Circular deque of 256 signed 32-bit elements with linear and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command items (cmd, value, index); o_out returns exactly one
//   result item (data, position, status, length) per command, in order.
//   The block takes one command at a time: i_in.ready is high only while the
//   sequencer is idle.
// Steps, from acceptance to the result being valid:
//   push, pop, write, clear, unused codes and any refused command: done in
//   the execute state. read: one pass through the registered storage read port.
//   linear search: one element visit per element examined, ending on a hit,
//   or on a miss once all length elements have been visited.
//   binary search: one element visit per probe, ending on a hit or a miss
//   (at most 9 probes for 256 elements).
//   Every element visit costs one storage read plus one comparator pass.
// Reset clears head, length and the sequencer and holds i_in.ready low; the
// storage is not cleared, and only positions below the length are reachable.
// Stall: the result sits in an output register until o_out.ready. The next
// command is accepted meanwhile, but it cannot finish until the held result
// has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_with_search_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rdq_in_if.sink      i_in,
    rdq_out_if.source   o_out
);
    import rdq_pkg::*;

    t_state             r_state, n_state;
    logic [CMDW-1:0]    r_cmd;
    t_elem              r_value;
    logic [IDXW-1:0]    r_index;
    t_addr              r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_end, n_end;
    t_addr              r_mid, n_mid;
    logic [POSW-1:0]    r_pos, n_pos;
    logic [STW-1:0]     r_status, n_status;
    t_elem              r_data, n_data;

    logic               r_out_valid;
    t_elem              r_out_data;
    logic [POSW-1:0]    r_out_pos;
    logic [STW-1:0]     r_out_status;
    logic [CW-1:0]      r_out_length;

    logic               accept;
    logic               out_free;
    logic               fin;
    logic               load_out;
    logic               mem_we;
    logic               wr_front;
    t_addr              mem_waddr;
    t_addr              mem_raddr;
    t_addr              slot_off;
    t_addr              slot;
    t_elem              rdata;
    logic               cmp_eq;
    logic               cmp_gt;
    logic [CW-1:0]      span;
    logic [CW-1:0]      mid_full;
    logic               full;
    logic               empty;
    logic               idx_ok;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign load_out = fin && out_free;
    assign full     = r_count[CW-1];
    assign empty    = (r_count == '0);
    assign idx_ok   = ({1'b0, r_index} < r_count);

    // Shared slot adder: logical offset to physical slot
    assign slot = r_head + slot_off;

    // Storage addresses: push front writes one slot before the head
    assign mem_raddr = slot;
    assign mem_waddr = wr_front ? (r_head - AW'(1)) : slot;

    // Shared comparator on the element just read
    assign cmp_eq = (rdata == r_value);
    assign cmp_gt = (rdata > r_value);

    // Binary search probe: lo + (hi - lo) / 2 with hi = end - 1
    assign span     = r_end - r_lo - CW'(1);
    assign mid_full = r_lo + (span >> 1);

    rdq_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_value),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_READ:       n_state = idx_ok ? ST_READ_WAIT : ST_DONE;
                    CMD_LIN_SEARCH: n_state = ST_LIN_RD;
                    CMD_BIN_SEARCH: n_state = ST_BIN_RD;
                    default:        n_state = ST_DONE;
                endcase
            end
            ST_READ_WAIT: n_state = ST_DONE;
            ST_LIN_RD:    n_state = (r_lo < r_count) ? ST_LIN_CMP : ST_DONE;
            ST_LIN_CMP:   n_state = cmp_eq ? ST_DONE : ST_LIN_RD;
            ST_BIN_RD:    n_state = (r_lo < r_end) ? ST_BIN_CMP : ST_DONE;
            ST_BIN_CMP:   n_state = cmp_eq ? ST_DONE : ST_BIN_RD;
            ST_DONE:      n_state = ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
        // Hand the result over as soon as the output register is free
        if (n_state == ST_DONE && r_state != ST_IDLE) begin
            n_state = ST_DONE;
        end
        if (load_out) begin
            n_state = ST_IDLE;
        end
    end

    // Datapath control and next values
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_lo     = r_lo;
        n_end    = r_end;
        n_mid    = r_mid;
        n_pos    = r_pos;
        n_status = r_status;
        n_data   = r_data;
        mem_we   = 1'b0;
        wr_front = 1'b0;
        slot_off = '0;
        fin      = 1'b0;

        case (r_state)
            ST_EXEC: begin
                case (r_cmd)
                    CMD_PUSH_BACK: begin
                        fin      = 1'b1;
                        slot_off = r_count[AW-1:0];
                        if (full) begin
                            n_status = STAT_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_PUSH_FRONT: begin
                        fin      = 1'b1;
                        wr_front = 1'b1;
                        if (full) begin
                            n_status = STAT_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_head  = r_head - AW'(1);
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_POP_BACK: begin
                        fin = 1'b1;
                        if (empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    CMD_POP_FRONT: begin
                        fin = 1'b1;
                        if (empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_head  = r_head + AW'(1);
                            n_count = r_count - CW'(1);
                        end
                    end
                    CMD_READ: begin
                        slot_off = r_index[AW-1:0];
                        if (!idx_ok) begin
                            fin      = 1'b1;
                            n_status = STAT_RANGE;
                        end
                    end
                    CMD_WRITE: begin
                        fin      = 1'b1;
                        slot_off = r_index[AW-1:0];
                        if (!idx_ok) begin
                            n_status = STAT_RANGE;
                        end else begin
                            mem_we = 1'b1;
                        end
                    end
                    CMD_LIN_SEARCH: begin
                        n_lo = '0;
                    end
                    CMD_BIN_SEARCH: begin
                        n_lo  = '0;
                        n_end = r_count;
                    end
                    CMD_CLEAR: begin
                        fin     = 1'b1;
                        n_head  = '0;
                        n_count = '0;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_READ_WAIT: begin
                fin    = 1'b1;
                n_data = rdata;
            end
            ST_LIN_RD: begin
                slot_off = r_lo[AW-1:0];
                if (r_lo >= r_count) begin
                    fin      = 1'b1;
                    n_status = STAT_MISS;
                end
            end
            ST_LIN_CMP: begin
                if (cmp_eq) begin
                    fin      = 1'b1;
                    n_pos    = POSW'(r_lo);
                    n_status = STAT_OK;
                end else begin
                    n_lo = r_lo + CW'(1);
                end
            end
            ST_BIN_RD: begin
                slot_off = mid_full[AW-1:0];
                n_mid    = mid_full[AW-1:0];
                if (r_lo >= r_end) begin
                    fin = 1'b1;
                    if (!empty && r_lo == r_count) begin
                        n_status = STAT_ABOVE;
                    end else begin
                        n_status = STAT_MISS;
                    end
                end
            end
            ST_BIN_CMP: begin
                if (cmp_eq) begin
                    fin      = 1'b1;
                    n_pos    = POSW'(r_mid);
                    n_status = STAT_OK;
                end else if (cmp_gt) begin
                    n_end = {1'b0, r_mid};
                end else begin
                    n_lo = {1'b0, r_mid} + CW'(1);
                end
            end
            ST_DONE: begin
                fin = 1'b1;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // Sequencer and deque state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Command capture and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_in.cmd;
            r_value  <= i_in.value;
            r_index  <= i_in.index;
            r_pos    <= '0;
            r_status <= STAT_OK;
            r_data   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_status <= n_status;
            r_data   <= n_data;
        end
        r_lo  <= n_lo;
        r_end <= n_end;
        r_mid <= n_mid;
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data   <= n_data;
            r_out_pos    <= n_pos;
            r_out_status <= n_status;
            r_out_length <= n_count;
        end
    end

    // Refuse commands while reset is held
    assign i_in.ready     = (r_state == ST_IDLE) && i_rst_n;
    assign o_out.valid    = r_out_valid;
    assign o_out.data     = r_out_data;
    assign o_out.position = r_out_pos;
    assign o_out.status   = r_out_status;
    assign o_out.length   = r_out_length;

endmodule

`default_nettype wire

FILE: rtl/core/rdq_checker.sv
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks on the ring deque, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdq_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  wire [rdq_pkg::STW-1:0] i_out_status,
    input  wire [rdq_pkg::CW-1:0]  i_out_length
);
    import rdq_pkg::*;

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // Take one command at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    // Full refusal only at capacity, empty refusal only at zero length
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == STAT_FULL |-> i_out_length == CW'(DEPTH))
        else $error("full status with length below capacity");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == STAT_EMPTY |-> i_out_length == '0)
        else $error("empty status with nonzero length");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ring_deque_with_search_top rdq_checker u_rdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_length (o_out.length)
);

`default_nettype wire
